### design/idsb_pkg.sv
// shared constants for the 2x2 box downscaler
// no dependencies; imported by image_downscale_box_2x2
package idsb_pkg;

  // widest frame the line buffer holds
  localparam int MAX_WIDTH = 2048;

  // configuration register widths, fixed by the register map
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  // column counter and effective width
  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW_W  = COL_W + 1;

  // line buffer split into even and odd column banks
  localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int SUM_W  = CHAN_W + 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

endpackage

### design/image_downscale_box_2x2.sv
// 2x2 box-filter downscaler, top level
// line buffer in two bank memories, valid/ready pipeline of block stage and output register
// depends on idsb_pkg
//
// usage:
//   input channel (in_valid/in_ready) takes one 24-bit pixel per beat in
//   raster order. every aligned 2x2 block yields one beat on the output
//   channel (out_valid/out_ready) carrying the floor average of each channel;
//   out_frame_last marks the final block of the frame. odd last column or row
//   is consumed without output, and counters wrap for the next frame.
//   cfg_we/cfg_index/cfg_data set image_width (index 0) and image_height
//   (index 1); write them only between frames.
// throughput: one pixel per clock while in_ready is high, set by the single
//   read and write port of each line-buffer bank (even row writes, odd row
//   reads, never both for one beat)
// pipeline: bank read and pixel capture into the block stage as the last
//   pixel of a block is accepted; the sums go into the output register and
//   raise out_valid when the block stage advances, which a stalled output holds off
// reset: counters and size registers clear (size back to 2x2); line buffer
//   content is undefined until the first even row fills it
// stall: with out_valid high and out_ready low, the output register and the
//   block stage hold; in_ready falls whenever both are full and the output
//   cannot drain, whatever the next pixel is
module image_downscale_box_2x2 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [idsb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [idsb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [idsb_pkg::CHAN_W-1:0]        in_blue_in,
  input  logic [idsb_pkg::CHAN_W-1:0]        in_green_in,
  input  logic [idsb_pkg::CHAN_W-1:0]        in_red_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [idsb_pkg::CHAN_W-1:0]        out_blue_avg,
  output logic [idsb_pkg::CHAN_W-1:0]        out_green_avg,
  output logic [idsb_pkg::CHAN_W-1:0]        out_red_avg,
  output logic                               out_frame_last
);
  import idsb_pkg::*;

  localparam logic [EW_W-1:0] MAX_W_V = EW_W'(MAX_WIDTH);

  // configuration registers
  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;

  // position counters and odd-row left pixel
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [CFG_HEIGHT_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0]        hold_r;

  // line buffer banks: even columns and odd columns
  logic [PIX_W-1:0] bank_even [BANK_DEPTH];
  logic [PIX_W-1:0] bank_odd  [BANK_DEPTH];

  // block stage
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_px_r, s1_hold_r, rd_even_r, rd_odd_r;
  logic             s1_last_r;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0] blue_r, green_r, red_r;
  logic             last_r;

  logic [EW_W-1:0]     eff_w;
  logic [CFG_HEIGHT_W-1:0] eff_h;
  logic [EW_W-1:0]     col_inc;
  logic [CFG_HEIGHT_W:0] row_inc;
  logic [EW_W-1:0]     last_col;
  logic [CFG_HEIGHT_W-1:0] last_row;
  logic                in_frame, produce, frame_end;
  logic                acc, s1_adv;
  logic                wr_even, wr_odd, take_hold;
  logic [ADDR_W-1:0]   addr;
  logic [PIX_W-1:0]    px;
  logic [SUM_W-1:0]    sum_b, sum_g, sum_r;

  // clamp the programmed size to what the buffer supports
  always_comb begin
    if (width_r < CFG_WIDTH_W'(2)) begin
      eff_w = EW_W'(2);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = MAX_W_V;
    end else begin
      eff_w = EW_W'(width_r);
    end
    eff_h = (height_r < CFG_HEIGHT_W'(2)) ? CFG_HEIGHT_W'(2) : height_r;
  end

  assign px   = {in_red_in, in_green_in, in_blue_in};
  assign addr = ADDR_W'(col_r >> 1);

  assign in_frame = (EW_W'(col_r) < eff_w) && (row_r < eff_h);
  assign produce  = in_frame && row_r[0] && col_r[0];

  // last block of the frame sits at the last even-aligned column and row
  assign last_col  = (eff_w & ~EW_W'(1)) - EW_W'(1);
  assign last_row  = (eff_h & ~CFG_HEIGHT_W'(1)) - CFG_HEIGHT_W'(1);
  assign frame_end = (EW_W'(col_r) == last_col) && (row_r == last_row);

  // handshake: block stage frees up whenever the output register can take it
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign acc      = in_valid && in_ready;

  assign wr_even   = acc && in_frame && !row_r[0] && !col_r[0];
  assign wr_odd    = acc && in_frame && !row_r[0] && col_r[0];
  assign take_hold = acc && in_frame && row_r[0] && !col_r[0];

  // counter advance with wrap at the frame edges
  always_comb begin
    col_inc = EW_W'(col_r) + EW_W'(1);
    row_inc = {1'b0, row_r} + (CFG_HEIGHT_W + 1)'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[CFG_HEIGHT_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
        if (row_r >= eff_h) begin
          row_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc && produce) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // four-pixel sums per channel
  always_comb begin
    sum_b = SUM_W'(rd_even_r[7:0]) + SUM_W'(rd_odd_r[7:0])
          + SUM_W'(s1_hold_r[7:0]) + SUM_W'(s1_px_r[7:0]);
    sum_g = SUM_W'(rd_even_r[15:8]) + SUM_W'(rd_odd_r[15:8])
          + SUM_W'(s1_hold_r[15:8]) + SUM_W'(s1_px_r[15:8]);
    sum_r = SUM_W'(rd_even_r[23:16]) + SUM_W'(rd_odd_r[23:16])
          + SUM_W'(s1_hold_r[23:16]) + SUM_W'(s1_px_r[23:16]);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CFG_WIDTH_W'(2);
      height_r    <= CFG_HEIGHT_W'(2);
      col_r       <= '0;
      row_r       <= '0;
      hold_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data[CFG_WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_r <= cfg_data[CFG_HEIGHT_W-1:0];
          default: ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      if (take_hold) begin
        hold_r <= px;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // line buffer writes on even rows
  always_ff @(posedge clk) begin
    if (wr_even) begin
      bank_even[addr] <= px;
    end
    if (wr_odd) begin
      bank_odd[addr] <= px;
    end
  end

  // line buffer reads on the beat that completes a block; held while stalled
  always_ff @(posedge clk) begin
    if (acc && produce) begin
      rd_even_r <= bank_even[addr];
      rd_odd_r  <= bank_odd[addr];
      s1_px_r   <= px;
      s1_hold_r <= hold_r;
      s1_last_r <= frame_end;
    end
  end

  // output register, floor of sum over four
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      blue_r  <= sum_b[SUM_W-1:2];
      green_r <= sum_g[SUM_W-1:2];
      red_r   <= sum_r[SUM_W-1:2];
      last_r  <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blue_avg   = blue_r;
  assign out_green_avg  = green_r;
  assign out_red_avg    = red_r;
  assign out_frame_last = last_r;

endmodule
